### rtl/core/xs96_pkg.sv
package xs96_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_RESEED = 2'd0,
    CMD_RAW    = 2'd1,
    CMD_RANGE  = 2'd2,
    CMD_BOUNDS = 2'd3
  } xs96_cmd_e;

  localparam word_t ResetX = 32'd123456789;
  localparam word_t ResetY = 32'd362436069;
  localparam word_t ResetZ = 32'd521288629;

  localparam int unsigned ShiftA = 16;
  localparam int unsigned ShiftB = 5;
  localparam int unsigned ShiftC = 1;

endpackage

### rtl/core/xorshift96_random_draw.sv
// xorshf96 random draw. A reseed word is taken on acceptance and gives no
// result. A raw draw, or a reduced draw whose divisor is zero (zero_divisor_o
// set, raw value returned), gives its result in the cycle after acceptance. A
// draw reduced modulo range_value_i or (high_bound_i - low_bound_i + 1) runs
// a shared restoring remainder unit at one quotient bit per cycle, and the
// result is registered once that unit signals done. in_ready_o is low from
// acceptance of a draw until its result word is taken.
module xorshift96_random_draw (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            cmd_i,
  input  xs96_pkg::word_t       seed_value_i,
  input  xs96_pkg::word_t       range_value_i,
  input  xs96_pkg::word_t       low_bound_i,
  input  xs96_pkg::word_t       high_bound_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output xs96_pkg::word_t       random_value_o,
  output logic                  zero_divisor_o
);
  import xs96_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e    state_q, state_d;
  logic      add_low_q, add_low_d;
  word_t     low_q, low_d;
  word_t     val_q, val_d;
  logic      flag_q, flag_d;
  xs96_cmd_e cmd;
  logic      accept;
  logic      gen_load, gen_adv;
  logic      rem_start, rem_done;
  word_t     z_next, rem;
  word_t     divisor;

  assign cmd    = xs96_cmd_e'(cmd_i);
  assign accept = in_valid_i && in_ready_o;

  assign divisor = (cmd == CMD_RANGE) ? range_value_i
                                      : (high_bound_i - low_bound_i + 32'd1);

  xs96_gen u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (gen_load),
    .advance_i (gen_adv),
    .seed_i    (seed_value_i),
    .z_next_o  (z_next)
  );

  xs96_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (z_next),
    .divisor_i  (divisor),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  always_comb begin
    state_d   = state_q;
    add_low_d = add_low_q;
    low_d     = low_q;
    val_d     = val_q;
    flag_d    = flag_q;
    gen_load  = 1'b0;
    gen_adv   = 1'b0;
    rem_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_RESEED) begin
            gen_load = 1'b1;
          end else begin
            gen_adv = 1'b1;
            if (cmd == CMD_RAW || divisor == '0) begin
              val_d   = z_next;
              flag_d  = (cmd != CMD_RAW);
              state_d = ST_OUT;
            end else begin
              rem_start = 1'b1;
              add_low_d = (cmd == CMD_BOUNDS);
              low_d     = low_bound_i;
              flag_d    = 1'b0;
              state_d   = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          val_d   = add_low_q ? (low_q + rem) : rem;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    add_low_q <= add_low_d;
    low_q     <= low_d;
    val_q     <= val_d;
    flag_q    <= flag_d;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = (state_q == ST_OUT);
  assign random_value_o = val_q;
  assign zero_divisor_o = flag_q;

endmodule

### rtl/core/xs96_gen.sv
module xs96_gen (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            advance_i,
  input  xs96_pkg::word_t seed_i,
  output xs96_pkg::word_t z_next_o
);
  import xs96_pkg::*;

  word_t x_q, y_q, z_q;
  word_t x_d, y_d, z_d;
  word_t t0, t1, t2;

  always_comb begin
    t0 = x_q ^ (x_q << ShiftA);
    t1 = t0 ^ (t0 >> ShiftB);
    t2 = t1 ^ (t1 << ShiftC);
  end

  assign z_next_o = t2 ^ y_q ^ z_q;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (load_i) begin
      x_d = seed_i;
    end else if (advance_i) begin
      x_d = y_q;
      y_d = z_q;
      z_d = z_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= ResetX;
      y_q <= ResetY;
      z_q <= ResetZ;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

endmodule

### rtl/core/xs96_rem.sv
module xs96_rem (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  xs96_pkg::word_t dividend_i,
  input  xs96_pkg::word_t divisor_i,
  output logic            done_o,
  output xs96_pkg::word_t rem_o
);
  import xs96_pkg::*;

  localparam int unsigned CntW = $clog2(WordW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  word_t           rem_q, rem_d;
  word_t           dvd_q, dvd_d;
  word_t           dsr_q, dsr_d;
  logic [WordW:0]  trial;
  logic [WordW:0]  diff;

  always_comb begin
    trial = {rem_q, dvd_q[WordW-1]};
    diff  = trial - {1'b0, dsr_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WordW - 1);
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = diff[WordW] ? trial[WordW-1:0] : diff[WordW-1:0];
      dvd_d = {dvd_q[WordW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
